// ===== hw/rtl/ckc_pkg.sv =====
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types, constants, keyword ROM and lexer helpers of the keyword counter.
// ----------------------------------------------------------------------------
package ckc_pkg;

  localparam int KEYWORD_TOTAL = 38;
  localparam int WORD_LIMIT    = 100;
  localparam int COUNT_BITS    = 16;
  localparam int KEEP_CHARS    = 10;
  localparam int IDX_BITS      = 6;
  localparam int LEN_BITS      = 7;
  localparam int OUT_CNT_BITS  = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]     keyword_index;
    logic [OUT_CNT_BITS-1:0] occurrence_count;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    LEX_GAP     = 3'd0,
    LEX_WORD    = 3'd1,
    LEX_HASH    = 3'd2,
    LEX_QUOTE   = 3'd3,
    LEX_SLASH   = 3'd4,
    LEX_COMMENT = 3'd5
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t           mode;
    logic [LEN_BITS-1:0] len;
    logic                qd;
    logic                esc;
    logic                star;
    logic                wr;
  } lex_t;

  // controller -> datapath
  typedef struct packed {
    logic lex_step;
    logic lex_clear;
    logic cap_idx;
    logic upd_rd;
    logic upd_wr;
    logic rpt_start;
    logic rpt_rd;
    logic rpt_next;
    logic load_out;
    logic valid_clear;
  } ckc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit_byte;
    logic hit_end;
    logic rpt_valid;
    logic rpt_at_end;
    logic out_free;
  } ckc_stat_t;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // keyword text, right aligned, first character in the highest used byte
  localparam logic [8*KEEP_CHARS-1:0] KW_TEXT [KEYWORD_TOTAL] = '{
    80'("auto"), 80'("break"), 80'("case"), 80'("char"), 80'("const"),
    80'("continue"), 80'("default"), 80'("do"), 80'("double"), 80'("else"),
    80'("enum"), 80'("extern"), 80'("float"), 80'("for"), 80'("goto"),
    80'("if"), 80'("inline"), 80'("int"), 80'("long"), 80'("register"),
    80'("restrict"), 80'("return"), 80'("short"), 80'("signed"),
    80'("sizeof"), 80'("static"), 80'("struct"), 80'("switch"),
    80'("typedef"), 80'("union"), 80'("unsigned"), 80'("void"),
    80'("volatile"), 80'("while"), 80'("_Bool"), 80'("_Complex"),
    80'("_Imaginary"), 80'("_Generic")
  };

  localparam logic [3:0] KW_LEN [KEYWORD_TOTAL] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4,
    4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2, 4'd6, 4'd3, 4'd4, 4'd8,
    4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5,
    4'd8, 4'd4, 4'd8, 4'd5, 4'd5, 4'd8, 4'd10, 4'd8
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // byte between tokens; may start a new token
  function automatic lex_t gap_step(input logic [7:0] c, input logic qd);
    lex_t r;
    r.mode = LEX_GAP;
    r.len  = '0;
    r.qd   = qd;
    r.esc  = 1'b0;
    r.star = 1'b0;
    r.wr   = 1'b0;
    if (is_space(c)) begin
      r.mode = LEX_GAP;
    end else if (is_letter(c) || c == CH_UNDER) begin
      r.mode = LEX_WORD;
      r.len  = LEN_BITS'(1);
      r.wr   = 1'b1;
    end else if (c == CH_HASH) begin
      r.mode = LEX_HASH;
      r.len  = LEN_BITS'(1);
      r.wr   = 1'b1;
    end else if (c == CH_SQ || c == CH_DQ) begin
      r.mode = LEX_QUOTE;
      r.len  = LEN_BITS'(1);
      r.qd   = (c == CH_DQ);
    end else if (c == CH_SLASH) begin
      r.mode = LEX_SLASH;
    end
    return r;
  endfunction

  // exact match of the kept characters; bit IDX_BITS is the hit flag
  function automatic logic [IDX_BITS:0] match_word(
    input logic [8*KEEP_CHARS-1:0] chars,
    input logic [LEN_BITS-1:0]     len
  );
    logic [IDX_BITS:0]         r;
    logic                      eq;
    logic [8*KEEP_CHARS-1:0]   sh;
    logic [3:0]                kl;
    r = '0;
    for (int k = KEYWORD_TOTAL - 1; k >= 0; k--) begin
      kl = KW_LEN[k];
      eq = (len == LEN_BITS'(kl));
      for (int i = 0; i < KEEP_CHARS; i++) begin
        if (i < int'(kl)) begin
          sh = KW_TEXT[k] >> (8 * (int'(kl) - 1 - i));
          if (chars[8*i +: 8] != sh[7:0]) eq = 1'b0;
        end
      end
      if (eq) r = {1'b1, IDX_BITS'(k)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ckc_datapath.sv =====
// ----------------------------------------------------------------------------
// ckc_datapath
// Lexer registers, keyword match, count memory and output register.
// ----------------------------------------------------------------------------
module ckc_datapath import ckc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  ckc_cmd_t  cmd,
  output ckc_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // lexer state
  lex_mode_t           lexer_mode;
  logic [LEN_BITS-1:0] word_length;
  logic                quote_is_double;
  logic                escape_pending;
  logic                star_seen;
  logic [7:0]          word_chars [KEEP_CHARS];

  lex_t                lex_next;
  logic                word_end;
  logic [LEN_BITS-1:0] wr_pos;
  logic [8*KEEP_CHARS-1:0] chars_flat;
  logic [IDX_BITS:0]   match;

  // counts
  logic [COUNT_BITS-1:0]    mem [KEYWORD_TOTAL];
  logic [KEYWORD_TOTAL-1:0] kw_valid;
  logic [COUNT_BITS-1:0]    rd_data;
  logic [IDX_BITS-1:0]      rd_addr;
  logic [IDX_BITS-1:0]      upd_idx;
  logic [IDX_BITS-1:0]      rpt_idx;
  logic [COUNT_BITS-1:0]    inc_val;
  logic [KEYWORD_TOTAL-1:0] above;
  logic                     out_last;

  always_comb begin
    for (int i = 0; i < KEEP_CHARS; i++) chars_flat[8*i +: 8] = word_chars[i];
  end

  assign match = match_word(chars_flat, word_length);

  // one byte through the lexer
  always_comb begin
    logic [7:0] c;
    c = in_data.ch;
    lex_next.mode = lexer_mode;
    lex_next.len  = word_length;
    lex_next.qd   = quote_is_double;
    lex_next.esc  = escape_pending;
    lex_next.star = star_seen;
    lex_next.wr   = 1'b0;
    word_end      = 1'b0;
    unique case (lexer_mode) inside
      LEX_WORD, LEX_HASH: begin
        if (!is_word_char(c)) begin
          word_end = (lexer_mode == LEX_WORD);
          lex_next = gap_step(c, quote_is_double);
        end else begin
          lex_next.wr  = (word_length < LEN_BITS'(KEEP_CHARS));
          lex_next.len = word_length + 1'b1;
          if (lex_next.len >= LEN_BITS'(WORD_LIMIT)) begin
            // word reaches the length limit: dropped
            lex_next.mode = LEX_GAP;
            lex_next.len  = '0;
          end
        end
      end
      LEX_QUOTE: begin
        if (escape_pending) begin
          lex_next.esc = 1'b0;
        end else begin
          lex_next.len = word_length + 1'b1;
          if (c == CH_BSL) begin
            lex_next.esc = 1'b1;
          end else if (c == (quote_is_double ? CH_DQ : CH_SQ)) begin
            lex_next.mode = LEX_GAP;
            lex_next.len  = '0;
          end
        end
        if (lex_next.mode == LEX_QUOTE && !lex_next.esc &&
            lex_next.len >= LEN_BITS'(WORD_LIMIT)) begin
          lex_next.mode = LEX_GAP;
          lex_next.len  = '0;
        end
      end
      LEX_SLASH: begin
        if (c == CH_STAR) begin
          lex_next.mode = LEX_COMMENT;
          lex_next.star = 1'b0;
        end else begin
          lex_next = gap_step(c, quote_is_double);
        end
      end
      LEX_COMMENT: begin
        if (star_seen && c == CH_SLASH) begin
          lex_next.mode = LEX_GAP;
          lex_next.star = 1'b0;
        end else begin
          lex_next.star = (c == CH_STAR);
        end
      end
      default: lex_next = gap_step(c, quote_is_double);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.lex_clear) begin
      lexer_mode      <= LEX_GAP;
      word_length     <= '0;
      quote_is_double <= 1'b0;
      escape_pending  <= 1'b0;
      star_seen       <= 1'b0;
    end else if (cmd.lex_step) begin
      lexer_mode      <= lex_next.mode;
      word_length     <= lex_next.len;
      quote_is_double <= lex_next.qd;
      escape_pending  <= lex_next.esc;
      star_seen       <= lex_next.star;
    end
  end

  // new character lands at the slot of the updated length
  assign wr_pos = lex_next.len - 1'b1;

  // kept characters; reset value not needed, only written entries are compared
  always_ff @(posedge clk) begin
    if (cmd.lex_step && lex_next.wr) begin
      word_chars[wr_pos[3:0]] <= in_data.ch;
    end
  end

  // count memory, registered read
  assign rd_addr = cmd.upd_rd ? upd_idx : rpt_idx;
  assign inc_val = kw_valid[upd_idx] ?
                   ((&rd_data) ? rd_data : rd_data + 1'b1) : COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.upd_rd || cmd.rpt_rd) rd_data <= mem[rd_addr];
    if (cmd.upd_wr) mem[upd_idx] <= inc_val;
    if (cmd.cap_idx) upd_idx <= match[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.valid_clear) begin
      kw_valid <= '0;
    end else if (cmd.upd_wr) begin
      kw_valid[upd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.rpt_start) begin
      rpt_idx <= '0;
    end else if (cmd.rpt_next) begin
      rpt_idx <= rpt_idx + 1'b1;
    end
  end

  assign above    = kw_valid >> ({1'b0, rpt_idx} + 7'd1);
  assign out_last = (above == '0);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.keyword_index    <= rpt_idx;
      out_data.occurrence_count <= OUT_CNT_BITS'(rd_data);
      out_data.last             <= out_last;
    end
  end

  assign stat.hit_byte   = word_end && match[IDX_BITS];
  assign stat.hit_end    = (lexer_mode == LEX_WORD) && match[IDX_BITS];
  assign stat.rpt_valid  = kw_valid[rpt_idx];
  assign stat.rpt_at_end = (rpt_idx == IDX_BITS'(KEYWORD_TOTAL - 1));
  assign stat.out_free   = !out_valid || !out_stall;

  // a literal may sit at the limit while its escaped byte is pending
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= LEN_BITS'(WORD_LIMIT))
    else $error("word length past limit");

  a_out_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_data.occurrence_count != '0)
    else $error("zero count reported");

endmodule

// ===== hw/rtl/ckc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckc_ctrl
// Sequencer: byte intake, count update and end-of-stream report walk.
// ----------------------------------------------------------------------------
module ckc_ctrl import ckc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_end,
  output logic      in_stall,
  input  ckc_stat_t stat,
  output ckc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPD_RD = 5'b00010,
    ST_UPD_WR = 5'b00100,
    ST_RPT_RD = 5'b01000,
    ST_RPT_WR = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   rpt_pending, rpt_pending_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next       = state;
    rpt_pending_next = rpt_pending;
    cmd              = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.cap_idx = 1'b1;
          if (in_end) begin
            cmd.lex_clear = 1'b1;
            if (stat.hit_end) begin
              rpt_pending_next = 1'b1;
              state_next       = ST_UPD_RD;
            end else begin
              cmd.rpt_start = 1'b1;
              state_next    = ST_RPT_RD;
            end
          end else begin
            cmd.lex_step = 1'b1;
            if (stat.hit_byte) state_next = ST_UPD_RD;
          end
        end
      end
      ST_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (rpt_pending) begin
          rpt_pending_next = 1'b0;
          cmd.rpt_start    = 1'b1;
          state_next       = ST_RPT_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RPT_RD: begin
        if (stat.rpt_valid) begin
          cmd.rpt_rd = 1'b1;
          state_next = ST_RPT_WR;
        end else if (stat.rpt_at_end) begin
          cmd.valid_clear = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.rpt_next = 1'b1;
        end
      end
      ST_RPT_WR: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.rpt_at_end) begin
            cmd.valid_clear = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            cmd.rpt_next = 1'b1;
            state_next   = ST_RPT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rpt_pending <= 1'b0;
    end else begin
      state       <= state_next;
      rpt_pending <= rpt_pending_next;
    end
  end

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD_WR |-> $past(state) == ST_UPD_RD)
    else $error("count write without read");

  a_pending_scope: assert property (@(posedge clk) disable iff (rst)
    rpt_pending |-> (state == ST_UPD_RD || state == ST_UPD_WR))
    else $error("report pending outside update");

endmodule

// ===== hw/rtl/c_keyword_counter_top.sv =====
// Intake: a byte that ends a keyword holds off the next byte while its count
//   is read from the count memory, then written (UPD_RD, then UPD_WR).
// Report: end of input walks all 38 count slots; an empty slot is skipped, a
//   counted one is read, then loaded out (held while the output stalls); a
//   stream that ends inside a keyword first updates that keyword's count.
// Reset: synchronous, clears lexer, count valid bits and output valid.
// ----------------------------------------------------------------------------
// c_keyword_counter_top
// Counts C keywords in a source byte stream and reports the counts on end
// of input.
// ----------------------------------------------------------------------------
module c_keyword_counter_top import ckc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  // byte items
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // report items
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ckc_cmd_t  cmd;
  ckc_stat_t stat;

  // sequencer: owns the input handshake, orders updates and the report walk
  ckc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_end   (in_data.end_of_input),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // lexer, keyword match, count memory with valid bits, output register
  ckc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
